// File: hw/rtl/dtq_pkg.sv
`default_nettype none
package dtq_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int MAX_OUT        = 16;
    localparam int OUT_IW         = 4;   // index into the expired list
    localparam int OUT_CW         = 5;   // expired count, 0..MAX_OUT
    localparam int TIME_W         = 52;
    localparam int PERIOD_W       = 40;
    localparam int LEAD_W         = 20;
    localparam int GEN_W          = 8;
    localparam int SLOT_W         = 4;
    localparam logic [LEAD_W-1:0] MIN_LEAD_RST = LEAD_W'(100);
    localparam logic [TIME_W-1:0] TIME_MAX     = {TIME_W{1'b1}};

    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_CANCEL = 2'd1,
        FUNC_TICK   = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_ADDED    = 3'd0,
        ST_FULL     = 3'd1,
        ST_CANCELED = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_EXPIRED  = 3'd4,
        ST_NONE     = 3'd5
    } status_t;

    typedef struct packed {
        logic [1:0]          func;
        logic [TIME_W-1:0]   now;
        logic [TIME_W-1:0]   deadline;
        logic [PERIOD_W-1:0] period;
        logic [SLOT_W-1:0]   slot_in;
        logic [GEN_W-1:0]    generation_in;
    } req_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [SLOT_W-1:0] slot;
        logic [GEN_W-1:0]  generation;
        logic              earliest_changed;
        logic              next_valid;
        logic [TIME_W-1:0] next_deadline;
        logic [TIME_W-1:0] arm_delay;
        logic              last;
    } rsp_t;

endpackage
`default_nettype wire

// File: hw/rtl/dtq_ram.sv
`default_nettype none
module dtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   aclk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: hw/rtl/deadline_timer_queue.sv
// Deadline timer queue: a table of NUM_TIMERS timers (deadline, period, generation).
// Requests enter on s_valid/s_ready with s_data (func, now, deadline, period,
// slot_in, generation_in); results leave on m_valid/m_ready with m_data.
// min_lead is written on cfg_valid/cfg_ready/cfg_data, always ready; the user must write it
// only while idle, which the block does not enforce. One request is in work at a time;
// s_ready is high only between requests. Every add, cancel and tick request scans the
// table one slot per cycle through the single deadline RAM read port and one pair of
// 52-bit compares. An add or cancel gives one result, also on a full table.
//   tick: one selection pass per expired timer, up to 16, plus a pass that finds
//   none while fewer than 16 are found; then a re-arm or free per expired timer,
//   the final earliest-deadline scan, the arm delay, then one result per expired timer.
//   func 3 is taken and dropped, no result.
// A stalled receiver holds the output register; the sequencer waits on it.
// Reset (aresetn low, synchronous) empties the table, clears generations to 0
// and sets min_lead to 100; no clearing pass is needed.
`default_nettype none
module deadline_timer_queue #(
    parameter int NUM_TIMERS = dtq_pkg::NUM_TIMERS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire dtq_pkg::req_t               s_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output dtq_pkg::rsp_t                    m_data,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [dtq_pkg::LEAD_W-1:0]  cfg_data
);
    localparam int IDXW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNTW = IDXW + 1;
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(NUM_TIMERS - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_ADD_FIND, S_ADD_RD, S_ADD_WR, S_CAN_RD, S_CAN_CHK,
        S_SEL, S_UPD_RD, S_UPD_WR, S_EARL, S_ARM, S_EMIT_RD, S_EMIT_OUT
    } state_t;

    state_t                        state_reg;
    dtq_pkg::req_t                 req_reg;
    logic [dtq_pkg::LEAD_W-1:0]    min_lead_reg;
    logic [NUM_TIMERS-1:0]         valid_reg;
    logic [NUM_TIMERS-1:0]         gen_wr_reg;
    logic [NUM_TIMERS-1:0]         taken_reg;
    logic [IDXW-1:0]               order_reg [dtq_pkg::MAX_OUT];
    logic [dtq_pkg::OUT_CW-1:0]    n_reg;
    logic [dtq_pkg::OUT_IW-1:0]    k_reg;
    logic [CNTW-1:0]               iss_reg;
    logic                          rdv_reg;
    logic [IDXW-1:0]               ridx_reg;
    logic                          found_reg;
    logic [dtq_pkg::TIME_W-1:0]    best_reg;
    logic [IDXW-1:0]               best_idx_reg;
    logic [IDXW-1:0]               free_idx_reg;
    logic                          excl_reg;
    logic [2:0]                    status_reg;
    logic                          ec_reg;
    logic                          nv_reg;
    logic [dtq_pkg::TIME_W-1:0]    nd_reg;
    logic [dtq_pkg::TIME_W-1:0]    ad_reg;
    logic [IDXW-1:0]               gen_ra_reg;
    logic                          m_valid_reg;
    dtq_pkg::rsp_t                 m_data_reg;

    // RAM ports
    logic                          dl_we, per_we, gen_we;
    logic [IDXW-1:0]               dl_waddr, dl_raddr, per_raddr, gen_raddr;
    logic [dtq_pkg::TIME_W-1:0]    dl_wdata, dl_rdata;
    logic [dtq_pkg::PERIOD_W-1:0]  per_rdata;
    logic [dtq_pkg::GEN_W-1:0]     gen_wdata, gen_rdata, gen_q;

    logic                          free_any;
    logic [IDXW-1:0]               free_idx;
    logic                          cand;
    logic                          scan_done;
    logic [dtq_pkg::TIME_W:0]      rearm_sum;
    logic [dtq_pkg::TIME_W-1:0]    rearm_dl;
    logic [dtq_pkg::TIME_W-1:0]    lead_diff;
    logic                          sin_ok;
    logic [IDXW-1:0]               sin_idx;
    logic [IDXW-1:0]               res_idx;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign gen_q     = gen_wr_reg[gen_ra_reg] ? gen_rdata : '0;
    assign sin_ok    = (32'(req_reg.slot_in) < NUM_TIMERS);
    assign sin_idx   = IDXW'(req_reg.slot_in);
    assign res_idx   = (req_reg.func == dtq_pkg::FUNC_TICK) ? order_reg[k_reg] : free_idx_reg;
    assign scan_done = rdv_reg && (ridx_reg == LAST_IDX);

    // lowest free slot
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_any = 1'b1;
                free_idx = IDXW'(i);
            end
        end
    end

    always_comb begin
        cand = 1'b0;
        if (state_reg == S_SEL) begin
            cand = valid_reg[ridx_reg] && !taken_reg[ridx_reg] &&
                   (dl_rdata <= req_reg.now) && (!found_reg || dl_rdata < best_reg);
        end else begin
            cand = valid_reg[ridx_reg] && !(excl_reg && ridx_reg == free_idx_reg) &&
                   (!found_reg || dl_rdata < best_reg);
        end
    end

    assign rearm_sum = {1'b0, req_reg.now} + (dtq_pkg::TIME_W + 1)'(per_rdata);
    assign rearm_dl  = rearm_sum[dtq_pkg::TIME_W] ? dtq_pkg::TIME_MAX
                                                  : rearm_sum[dtq_pkg::TIME_W-1:0];
    assign lead_diff = (nd_reg > req_reg.now) ? nd_reg - req_reg.now : '0;

    always_comb begin
        dl_we     = 1'b0;
        dl_waddr  = free_idx_reg;
        dl_wdata  = req_reg.deadline;
        dl_raddr  = iss_reg[IDXW-1:0];
        per_we    = (state_reg == S_ADD_WR);
        per_raddr = order_reg[k_reg];
        gen_we    = (state_reg == S_ADD_WR);
        gen_wdata = gen_q + 1'b1;
        gen_raddr = res_idx;
        unique case (state_reg)
            S_ADD_WR: dl_we = 1'b1;
            S_UPD_WR: begin
                dl_we    = (per_rdata != '0);
                dl_waddr = order_reg[k_reg];
                dl_wdata = rearm_dl;
            end
            S_CAN_RD: gen_raddr = sin_idx;
            default: ;
        endcase
    end

    dtq_ram #(.WIDTH(dtq_pkg::TIME_W), .DEPTH(NUM_TIMERS)) u_dl_ram (
        .aclk(aclk), .we(dl_we), .waddr(dl_waddr), .wdata(dl_wdata),
        .raddr(dl_raddr), .rdata(dl_rdata)
    );
    dtq_ram #(.WIDTH(dtq_pkg::PERIOD_W), .DEPTH(NUM_TIMERS)) u_per_ram (
        .aclk(aclk), .we(per_we), .waddr(free_idx_reg), .wdata(req_reg.period),
        .raddr(per_raddr), .rdata(per_rdata)
    );
    dtq_ram #(.WIDTH(dtq_pkg::GEN_W), .DEPTH(NUM_TIMERS)) u_gen_ram (
        .aclk(aclk), .we(gen_we), .waddr(free_idx_reg), .wdata(gen_wdata),
        .raddr(gen_raddr), .rdata(gen_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            min_lead_reg <= dtq_pkg::MIN_LEAD_RST;
            valid_reg    <= '0;
            gen_wr_reg   <= '0;
            m_valid_reg  <= 1'b0;
            rdv_reg      <= 1'b0;
            iss_reg      <= '0;
            n_reg        <= '0;
            k_reg        <= '0;
            found_reg    <= 1'b0;
            taken_reg    <= '0;
        end else begin
            if (cfg_valid) begin
                min_lead_reg <= cfg_data;
            end
            // the emit state reloads the output register itself
            if (m_valid_reg && m_ready && state_reg != S_EMIT_OUT) begin
                m_valid_reg <= 1'b0;
            end
            gen_ra_reg <= gen_raddr;

            // shared scan pipeline: address issue, registered read, compare
            if ((state_reg == S_SEL || state_reg == S_EARL) && !scan_done) begin
                if (iss_reg < CNTW'(NUM_TIMERS)) begin
                    iss_reg <= iss_reg + 1'b1;
                    rdv_reg <= 1'b1;
                end else begin
                    rdv_reg <= 1'b0;
                end
                ridx_reg <= iss_reg[IDXW-1:0];
                if (rdv_reg && cand) begin
                    found_reg    <= 1'b1;
                    best_reg     <= dl_rdata;
                    best_idx_reg <= ridx_reg;
                end
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        req_reg   <= s_data;
                        n_reg     <= '0;
                        k_reg     <= '0;
                        excl_reg  <= 1'b0;
                        ec_reg    <= 1'b0;
                        taken_reg <= '0;
                        iss_reg   <= '0;
                        rdv_reg   <= 1'b0;
                        found_reg <= 1'b0;
                        unique case (s_data.func)
                            dtq_pkg::FUNC_ADD:    state_reg <= S_ADD_FIND;
                            dtq_pkg::FUNC_CANCEL: state_reg <= S_CAN_RD;
                            dtq_pkg::FUNC_TICK:   state_reg <= S_SEL;
                            default:              state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_ADD_FIND: begin
                    free_idx_reg <= free_idx;
                    if (free_any) begin
                        state_reg <= S_ADD_RD;
                    end else begin
                        status_reg <= dtq_pkg::ST_FULL;
                        state_reg  <= S_EARL;
                    end
                end
                S_ADD_RD: state_reg <= S_ADD_WR;
                S_ADD_WR: begin
                    valid_reg[free_idx_reg]  <= 1'b1;
                    gen_wr_reg[free_idx_reg] <= 1'b1;
                    status_reg <= dtq_pkg::ST_ADDED;
                    excl_reg   <= 1'b1;
                    state_reg  <= S_EARL;
                end
                S_CAN_RD: state_reg <= S_CAN_CHK;
                S_CAN_CHK: begin
                    if (sin_ok && valid_reg[sin_idx] && gen_q == req_reg.generation_in) begin
                        valid_reg[sin_idx] <= 1'b0;
                        status_reg <= dtq_pkg::ST_CANCELED;
                    end else begin
                        status_reg <= dtq_pkg::ST_NOTFOUND;
                    end
                    state_reg <= S_EARL;
                end
                S_SEL: begin
                    if (scan_done) begin
                        iss_reg   <= '0;
                        rdv_reg   <= 1'b0;
                        found_reg <= 1'b0;
                        if (found_reg || (rdv_reg && cand)) begin
                            order_reg[n_reg[dtq_pkg::OUT_IW-1:0]] <=
                                cand ? ridx_reg : best_idx_reg;
                            taken_reg[cand ? ridx_reg : best_idx_reg] <= 1'b1;
                            n_reg <= n_reg + 1'b1;
                            if (n_reg == dtq_pkg::OUT_CW'(dtq_pkg::MAX_OUT - 1)) begin
                                state_reg <= S_UPD_RD;
                            end
                        end else if (n_reg == '0) begin
                            status_reg <= dtq_pkg::ST_NONE;
                            state_reg  <= S_EARL;
                        end else begin
                            state_reg <= S_UPD_RD;
                        end
                    end
                end
                S_UPD_RD: state_reg <= S_UPD_WR;
                S_UPD_WR: begin
                    if (per_rdata == '0) begin
                        valid_reg[order_reg[k_reg]] <= 1'b0;
                    end
                    if (dtq_pkg::OUT_CW'(k_reg) == n_reg - 1'b1) begin
                        k_reg      <= '0;
                        status_reg <= dtq_pkg::ST_EXPIRED;
                        iss_reg    <= '0;
                        rdv_reg    <= 1'b0;
                        found_reg  <= 1'b0;
                        state_reg  <= S_EARL;
                    end else begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_UPD_RD;
                    end
                end
                S_EARL: begin
                    if (scan_done) begin
                        // with excl set the scan saw the table as it was before the add
                        if (excl_reg) begin
                            nv_reg <= 1'b1;
                            if (!(found_reg || cand) ||
                                req_reg.deadline < (cand ? dl_rdata : best_reg)) begin
                                ec_reg <= 1'b1;
                                nd_reg <= req_reg.deadline;
                            end else begin
                                nd_reg <= cand ? dl_rdata : best_reg;
                            end
                        end else begin
                            nv_reg <= found_reg || cand;
                            nd_reg <= cand ? dl_rdata : (found_reg ? best_reg : '0);
                        end
                        state_reg <= S_ARM;
                    end
                end
                S_ARM: begin
                    if (!nv_reg) begin
                        ad_reg <= '0;
                    end else if (lead_diff < dtq_pkg::TIME_W'(min_lead_reg)) begin
                        ad_reg <= dtq_pkg::TIME_W'(min_lead_reg);
                    end else begin
                        ad_reg <= lead_diff;
                    end
                    if (n_reg == '0) begin
                        n_reg <= dtq_pkg::OUT_CW'(1);
                    end
                    state_reg <= S_EMIT_RD;
                end
                S_EMIT_RD: state_reg <= S_EMIT_OUT;
                S_EMIT_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg                  <= 1'b1;
                        m_data_reg.status            <= status_reg;
                        m_data_reg.earliest_changed  <= ec_reg;
                        m_data_reg.next_valid        <= nv_reg;
                        m_data_reg.next_deadline     <= nd_reg;
                        m_data_reg.arm_delay         <= ad_reg;
                        m_data_reg.last <= (dtq_pkg::OUT_CW'(k_reg) == n_reg - 1'b1);
                        if (status_reg == dtq_pkg::ST_ADDED ||
                            status_reg == dtq_pkg::ST_EXPIRED) begin
                            m_data_reg.slot       <= dtq_pkg::SLOT_W'(res_idx);
                            m_data_reg.generation <= gen_q;
                        end else begin
                            m_data_reg.slot       <= '0;
                            m_data_reg.generation <= '0;
                        end
                        if (dtq_pkg::OUT_CW'(k_reg) == n_reg - 1'b1) begin
                            state_reg <= S_IDLE;
                        end else begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= S_EMIT_RD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= dtq_pkg::OUT_CW'(dtq_pkg::MAX_OUT))
        else $error("expired count beyond limit");

    a_taken_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SEL) |-> ((taken_reg & ~valid_reg) == '0))
        else $error("selected timer is not live");

    a_idle_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.status != dtq_pkg::ST_ADDED &&
         m_data_reg.status != dtq_pkg::ST_EXPIRED)
        |-> (m_data_reg.slot == '0 && m_data_reg.generation == '0))
        else $error("handle reported on a result without one");

    a_next_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.next_valid)
        |-> (m_data_reg.next_deadline == '0 && m_data_reg.arm_delay == '0))
        else $error("next deadline reported with empty table");

endmodule
`default_nettype wire

// File: verif/tb_top.sv
`default_nettype none
module tb_top;

    localparam int N_SLOTS   = 16;
    localparam int IDLE_MAX  = 11;
    localparam int WDOG_MAX  = 20000;
    localparam int DRAIN_CYC = 600;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    dtq_pkg::req_t s_data;
    logic m_valid;
    logic m_ready;
    dtq_pkg::rsp_t m_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [dtq_pkg::LEAD_W-1:0] cfg_data;

    deadline_timer_queue u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // shadow of the timer table
    logic                         tq_valid [N_SLOTS];
    logic [dtq_pkg::TIME_W-1:0]   tq_dl    [N_SLOTS];
    logic [dtq_pkg::PERIOD_W-1:0] tq_per   [N_SLOTS];
    logic [dtq_pkg::GEN_W-1:0]    tq_gen   [N_SLOTS];
    logic [dtq_pkg::LEAD_W-1:0]   lead_q;

    dtq_pkg::rsp_t expected_rsp[$];
    int   n_errors;
    int   idle_cycles;
    bit   rx_hold;
    bit   rx_no_stall;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic earliest_dl(output logic [dtq_pkg::TIME_W-1:0] dl);
        logic any;
        any = 1'b0;
        dl  = '0;
        for (int i = 0; i < N_SLOTS; i++) begin
            if (tq_valid[i] && (!any || tq_dl[i] < dl)) begin
                dl  = tq_dl[i];
                any = 1'b1;
            end
        end
        return any;
    endfunction

    function automatic dtq_pkg::rsp_t make_rsp(dtq_pkg::status_t st, int sl,
                                               logic [dtq_pkg::GEN_W-1:0] g, logic ec,
                                               logic [dtq_pkg::TIME_W-1:0] now, logic lst);
        dtq_pkg::rsp_t r;
        logic [dtq_pkg::TIME_W-1:0] nd;
        r = '0;
        r.status = st;
        r.slot = sl[dtq_pkg::SLOT_W-1:0];
        r.generation = g;
        r.earliest_changed = ec;
        r.next_valid = earliest_dl(nd);
        r.next_deadline = nd;
        if (r.next_valid) begin
            r.arm_delay = (nd > now) ? nd - now : '0;
            if (r.arm_delay < dtq_pkg::TIME_W'(lead_q)) r.arm_delay = dtq_pkg::TIME_W'(lead_q);
        end
        r.last = lst;
        return r;
    endfunction

    // update the shadow table and queue up the results of one request
    task automatic predict_timers(dtq_pkg::req_t q);
        logic [dtq_pkg::TIME_W-1:0] cur;
        logic had;
        int fs;
        int order[$];
        logic taken[N_SLOTS];
        int b;
        logic [dtq_pkg::TIME_W:0] sum;
        case (dtq_pkg::func_t'(q.func))
            dtq_pkg::FUNC_ADD: begin
                had = earliest_dl(cur);
                fs = -1;
                for (int i = N_SLOTS - 1; i >= 0; i--) if (!tq_valid[i]) fs = i;
                if (fs < 0) begin
                    expected_rsp.push_back(make_rsp(dtq_pkg::ST_FULL, 0, '0, 1'b0,
                                                    q.now, 1'b1));
                end else begin
                    tq_gen[fs]++;
                    tq_valid[fs] = 1'b1;
                    tq_dl[fs] = q.deadline;
                    tq_per[fs] = q.period;
                    expected_rsp.push_back(make_rsp(dtq_pkg::ST_ADDED, fs, tq_gen[fs],
                        !had || q.deadline < cur, q.now, 1'b1));
                end
            end
            dtq_pkg::FUNC_CANCEL: begin
                if (tq_valid[q.slot_in] && tq_gen[q.slot_in] == q.generation_in) begin
                    tq_valid[q.slot_in] = 1'b0;
                    expected_rsp.push_back(make_rsp(dtq_pkg::ST_CANCELED, 0, '0, 1'b0,
                                                    q.now, 1'b1));
                end else begin
                    expected_rsp.push_back(make_rsp(dtq_pkg::ST_NOTFOUND, 0, '0, 1'b0,
                                                    q.now, 1'b1));
                end
            end
            dtq_pkg::FUNC_TICK: begin
                for (int i = 0; i < N_SLOTS; i++) taken[i] = 1'b0;
                while (order.size() < dtq_pkg::MAX_OUT) begin
                    b = -1;
                    for (int i = 0; i < N_SLOTS; i++)
                        if (tq_valid[i] && !taken[i] && tq_dl[i] <= q.now &&
                            (b < 0 || tq_dl[i] < tq_dl[b])) b = i;
                    if (b < 0) break;
                    taken[b] = 1'b1;
                    order.push_back(b);
                end
                if (order.size() == 0) begin
                    expected_rsp.push_back(make_rsp(dtq_pkg::ST_NONE, 0, '0, 1'b0,
                                                    q.now, 1'b1));
                end else begin
                    foreach (order[k]) begin
                        if (tq_per[order[k]] != 0) begin
                            sum = {1'b0, q.now} + (dtq_pkg::TIME_W + 1)'(tq_per[order[k]]);
                            tq_dl[order[k]] = sum[dtq_pkg::TIME_W] ? dtq_pkg::TIME_MAX
                                                                   : sum[dtq_pkg::TIME_W-1:0];
                        end else begin
                            tq_valid[order[k]] = 1'b0;
                        end
                    end
                    foreach (order[k])
                        expected_rsp.push_back(make_rsp(dtq_pkg::ST_EXPIRED, order[k],
                            tq_gen[order[k]], 1'b0, q.now, k == order.size() - 1));
                end
            end
            default: ;
        endcase
    endtask

    // returns at the accepting edge; the next negedge either offers the
    // following request or drops valid
    task automatic send_request(dtq_pkg::req_t q, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, IDLE_MAX);
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data  <= q;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_timers(q);
    endtask

    function automatic dtq_pkg::req_t rand_req(dtq_pkg::func_t f);
        dtq_pkg::req_t q;
        logic [191:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        q = raw[$bits(dtq_pkg::req_t)-1:0];
        q.func = f;
        return q;
    endfunction

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_rsp.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYC) @(negedge aclk);
    endtask

    task automatic write_lead(logic [dtq_pkg::LEAD_W-1:0] v);
        wait_drained();
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        lead_q = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic dtq_pkg::req_t mk(dtq_pkg::func_t f, logic [dtq_pkg::TIME_W-1:0] now,
                                         logic [dtq_pkg::TIME_W-1:0] dl,
                                         logic [dtq_pkg::PERIOD_W-1:0] per, int sl, int g);
        dtq_pkg::req_t q;
        q = '0;
        q.func = f;
        q.now = now;
        q.deadline = dl;
        q.period = per;
        q.slot_in = sl[dtq_pkg::SLOT_W-1:0];
        q.generation_in = g[dtq_pkg::GEN_W-1:0];
        return q;
    endfunction

    task automatic test_directed();
        send_request(mk(dtq_pkg::FUNC_TICK, 0, 0, 0, 0, 0));          // empty table
        send_request(mk(dtq_pkg::FUNC_CANCEL, 5, 0, 0, 0, 1));        // free slot
        send_request(mk(dtq_pkg::FUNC_ADD, 10, 500, 0, 0, 0));
        send_request(mk(dtq_pkg::FUNC_ADD, 10, 400, 300, 0, 0));
        send_request(mk(dtq_pkg::FUNC_ADD, 10, 450, 0, 0, 0));
        send_request(mk(dtq_pkg::FUNC_CANCEL, 10, 0, 0, 0, 2));       // wrong generation
        send_request(mk(dtq_pkg::FUNC_CANCEL, 10, 0, 0, 2, 1));
        send_request(mk(dtq_pkg::FUNC_NONE, 10, 0, 0, 0, 0));
        send_request(mk(dtq_pkg::FUNC_TICK, 420, 0, 0, 0, 0));
        send_request(mk(dtq_pkg::FUNC_ADD, dtq_pkg::TIME_MAX, dtq_pkg::TIME_MAX,
                        {dtq_pkg::PERIOD_W{1'b1}}, 15, 255));
        // re-arm saturates
        send_request(mk(dtq_pkg::FUNC_TICK, dtq_pkg::TIME_MAX, 0, 0, 0, 0));
        send_request(mk(dtq_pkg::FUNC_TICK, dtq_pkg::TIME_MAX, 0, 0, 0, 0));
        for (int i = 0; i < N_SLOTS; i++)
            send_request(mk(dtq_pkg::FUNC_CANCEL, 0, 0, 0, i, tq_gen[i]));
    endtask

    task automatic test_full_table();
        for (int i = 0; i < N_SLOTS + 1; i++)
            send_request(mk(dtq_pkg::FUNC_ADD, 0, 50 - i, i % 2, 0, 0));
        // all sixteen expire in one tick, reverse slot order
        send_request(mk(dtq_pkg::FUNC_TICK, 100, 0, 0, 0, 0));
        send_request(mk(dtq_pkg::FUNC_TICK, 200, 0, 0, 0, 0));
        send_request(mk(dtq_pkg::FUNC_TICK, 300, 0, 0, 0, 0));
    endtask

    task automatic test_random(int n_req);
        dtq_pkg::req_t q;
        int sl;
        logic [dtq_pkg::TIME_W-1:0] base;
        base = $urandom_range(0, 1000);
        for (int i = 0; i < n_req; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    q = rand_req(dtq_pkg::FUNC_ADD);
                    q.now = base;
                    if ($urandom_range(0, 7) != 0) begin
                        q.deadline = base + $urandom_range(0, 400);
                        q.period = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 300) : 0;
                    end
                end
                4, 5: begin
                    q = rand_req(dtq_pkg::FUNC_CANCEL);
                    q.now = base;
                    sl = $urandom_range(0, N_SLOTS - 1);
                    if ($urandom_range(0, 3) != 0) begin
                        q.slot_in = sl;
                        q.generation_in = tq_gen[sl];
                    end
                end
                6, 7, 8: begin
                    q = rand_req(dtq_pkg::FUNC_TICK);
                    base = base + $urandom_range(0, 200);
                    q.now = ($urandom_range(0, 15) == 0) ? q.now : base;
                end
                default: q = rand_req(dtq_pkg::func_t'($urandom_range(0, 3)));
            endcase
            send_request(q);
        end
    endtask

    task automatic test_backpressure();
        rx_hold = 1;
        for (int i = 0; i < 6; i++) send_request(mk(dtq_pkg::FUNC_ADD, 0, i, 0, 0, 0), 1);
        rx_hold = 0;
        wait_drained();   // sender pauses until every result is back
        send_request(mk(dtq_pkg::FUNC_TICK, 100, 0, 0, 0, 0));
    endtask

    // receiver side
    initial begin
        int gap;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold) begin
                m_ready <= 1'b0;
                repeat (300) @(negedge aclk);
            end
            gap = rx_no_stall ? 0 : $urandom_range(0, IDLE_MAX);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // result checker
    always @(posedge aclk) begin
        dtq_pkg::rsp_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_rsp.size() == 0) begin
                $display("%0t: unexpected result %p", $time, m_data);
                n_errors++;
            end else begin
                e = expected_rsp.pop_front();
                if (m_data !== e) begin
                    $display("%0t: result mismatch, expected %p, actual %p", $time, e, m_data);
                    n_errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_MAX) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        n_errors    = 0;
        idle_cycles = 0;
        rx_hold     = 0;
        rx_no_stall = 0;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        lead_q    = dtq_pkg::MIN_LEAD_RST;
        for (int i = 0; i < N_SLOTS; i++) begin
            tq_valid[i] = 1'b0;
            tq_dl[i]    = '0;
            tq_per[i]   = '0;
            tq_gen[i]   = '0;
        end
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_full_table();
        write_lead('0);
        test_backpressure();
        test_random(100);
        write_lead({dtq_pkg::LEAD_W{1'b1}});
        rx_no_stall = 1;
        test_random(60);
        rx_no_stall = 0;
        write_lead(dtq_pkg::LEAD_W'($urandom));
        test_random(110);
        wait_drained();

        if (n_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
hw/rtl/dtq_pkg.sv
hw/rtl/dtq_ram.sv
hw/rtl/deadline_timer_queue.sv
verif/tb_top.sv
